// ===== design/dedup_point_recorder_assert.svh =====
// Assertion macros shared by the recorder checker.
`ifndef DEDUP_POINT_RECORDER_ASSERT_SVH
`define DEDUP_POINT_RECORDER_ASSERT_SVH

// Same-cycle implication, clocked on clk and quiet during reset
`define DPR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and quiet during reset
`define DPR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dpr_pkg.sv =====
// Shared types and codes of the deduplicating access-point recorder.
package dpr_pkg;

  // Table size default
  localparam int unsigned CAPACITY_DEF = 256;

  // Field widths
  localparam int unsigned ACTION_W    = 2;
  localparam int unsigned TAG_W       = 32;
  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned CTX_W       = 64;
  localparam int unsigned READ_IDX_W  = 8;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned COUNT_OUT_W = 9;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 32;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_STORE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_STORED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_IGNORED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_READ_OK    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_READ_RANGE = 3'd6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRUSTED = 1'd1;

  // One table entry as held in the RAM
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              kind;
    logic [CTX_W-1:0]  ctx;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

// ===== design/dedup_point_recorder.sv =====
// Deduplicating access-point recorder: event table in RAM, walked one entry a cycle.
//
// Items are taken on start while busy is low; each gives exactly one result, shown for
// one cycle with done high, and the receiver cannot stall it. Clear, ignored and
// table-full items answer in the cycle after acceptance without raising busy. A read
// answers through one registered RAM read in S_READ. A store or load event walks the
// held entries through the single RAM read port, one entry per cycle, and stops
// early when a duplicate is found (the walk stops at the match). The longest walk
// is with CAPACITY - 1 entries held. Configuration writes are always ready and should be
// made while no item is in flight.
module dedup_point_recorder #(
  parameter int unsigned CAPACITY = dpr_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic [dpr_pkg::ACTION_W-1:0]        action,
  input  logic                                in_interrupt_ctx,
  input  logic [dpr_pkg::TAG_W-1:0]           task_tag,
  input  logic [dpr_pkg::ADDR_W-1:0]          return_addr,
  input  logic [dpr_pkg::CTX_W-1:0]           context_hash,
  input  logic [dpr_pkg::READ_IDX_W-1:0]      read_index,
  // result channel
  output logic                                done,
  output logic [dpr_pkg::STATUS_W-1:0]        status,
  output logic [dpr_pkg::ADDR_W-1:0]          entry_addr,
  output logic                                entry_kind,
  output logic [dpr_pkg::CTX_W-1:0]           entry_context,
  output logic [dpr_pkg::COUNT_OUT_W-1:0]     entry_count,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dpr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dpr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import dpr_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > READ_IDX_W) ? CW : READ_IDX_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ
  } state_t;

  state_t            state;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     cnt_inc;
  logic [CW-1:0]     ptr;
  logic              rd_vld;
  logic              rec_en;
  logic [TAG_W-1:0]  trusted_tag;

  // latched event key
  logic              key_store;
  logic [ADDR_W-1:0] key_addr;
  logic [CTX_W-1:0]  key_ctx;

  // RAM ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  entry_t            ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  entry_t            ram_rdata;

  logic              accept;
  logic              ignored;
  logic              full;
  logic [XW-1:0]     idx_x;
  logic [XW-1:0]     cnt_x;
  logic              idx_ok;
  logic              hit;
  logic              scan_end;
  logic [CW+8:0]     cnt_wide;
  logic [CW+8:0]     inc_wide;

  // Event qualification and read-range check
  assign accept   = start && !busy;
  assign ignored  = !rec_en || in_interrupt_ctx || (task_tag != trusted_tag);
  assign full     = (cnt == CW'(CAPACITY));
  assign idx_x    = XW'(read_index);
  assign cnt_x    = XW'(cnt);
  assign idx_ok   = (idx_x < cnt_x);
  assign cnt_inc  = cnt + 1'b1;
  assign cnt_wide = (CW + 9)'(cnt);
  assign inc_wide = (CW + 9)'(cnt_inc);

  // Compare against the entry read in the previous cycle
  assign hit      = rd_vld && (ram_rdata.addr == key_addr) &&
                    (key_store || (ram_rdata.ctx == key_ctx));
  assign scan_end = !rd_vld && (ptr == cnt);

  // RAM access control
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = ptr[AW-1:0];
    if (state == S_IDLE) begin
      ram_raddr = idx_x[AW-1:0];
      ram_re    = accept && (action == ACT_READ) && idx_ok;
    end else if (state == S_SCAN) begin
      ram_re    = (ptr != cnt);
    end
  end

  assign ram_we         = (state == S_SCAN) && !hit && scan_end;
  assign ram_waddr      = cnt[AW-1:0];
  assign ram_wdata.addr = key_addr;
  assign ram_wdata.kind = key_store;
  assign ram_wdata.ctx  = key_ctx;

  dpr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_en      <= 1'b0;
      trusted_tag <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENABLE:  rec_en      <= cfg_data[0];
        REG_TRUSTED: trusted_tag <= cfg_data;
        default:     ;
      endcase
    end
  end

  // Sequencer, table count and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      cnt    <= '0;
      ptr    <= '0;
      rd_vld <= 1'b0;
    end else begin
      done   <= 1'b0;
      rd_vld <= ram_re && (state == S_SCAN);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            entry_addr    <= '0;
            entry_kind    <= 1'b0;
            entry_context <= '0;
            entry_count   <= cnt_wide[COUNT_OUT_W-1:0];
            unique case (action) inside
              ACT_STORE, ACT_LOAD: begin
                if (ignored) begin
                  done   <= 1'b1;
                  status <= ST_IGNORED;
                end else if (full) begin
                  done   <= 1'b1;
                  status <= ST_FULL;
                end else begin
                  key_store <= (action == ACT_STORE);
                  key_addr  <= return_addr;
                  key_ctx   <= context_hash;
                  ptr       <= '0;
                  state     <= S_SCAN;
                end
              end
              ACT_CLEAR: begin
                cnt         <= '0;
                done        <= 1'b1;
                status      <= ST_CLEARED;
                entry_count <= '0;
              end
              default: begin
                if (idx_ok) begin
                  state <= S_READ;
                end else begin
                  done   <= 1'b1;
                  status <= ST_READ_RANGE;
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          if (ptr != cnt) begin
            ptr <= ptr + 1'b1;
          end
          if (hit) begin
            done          <= 1'b1;
            status        <= ST_DUPLICATE;
            entry_addr    <= '0;
            entry_kind    <= 1'b0;
            entry_context <= '0;
            entry_count   <= cnt_wide[COUNT_OUT_W-1:0];
            state         <= S_IDLE;
          end else if (scan_end) begin
            // no match found: entry appended this cycle
            cnt           <= cnt_inc;
            done          <= 1'b1;
            status        <= ST_STORED;
            entry_addr    <= '0;
            entry_kind    <= 1'b0;
            entry_context <= '0;
            entry_count   <= inc_wide[COUNT_OUT_W-1:0];
            state         <= S_IDLE;
          end
        end
        S_READ: begin
          done          <= 1'b1;
          status        <= ST_READ_OK;
          entry_addr    <= ram_rdata.addr;
          entry_kind    <= ram_rdata.kind;
          entry_context <= ram_rdata.ctx;
          entry_count   <= cnt_wide[COUNT_OUT_W-1:0];
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/dpr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/dpr_checker.sv =====
// Port-level checker for the recorder, bound to its top level.
`include "dedup_point_recorder_assert.svh"

module dpr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            done,
  input logic [dpr_pkg::STATUS_W-1:0]    status,
  input logic [dpr_pkg::ADDR_W-1:0]      entry_addr,
  input logic                            entry_kind,
  input logic [dpr_pkg::CTX_W-1:0]       entry_context,
  input logic [dpr_pkg::COUNT_OUT_W-1:0] entry_count
);

  import dpr_pkg::*;

  // an accepted item is either answered next cycle or holds the block busy
  `DPR_ASSERT_NXT(a_accept_progress, start && !busy, busy || done, "accepted item lost")

  // entry fields are zero unless a read succeeded
  `DPR_ASSERT_IMP(a_fields_zero, done && (status != ST_READ_OK),
    (entry_addr == '0) && !entry_kind && (entry_context == '0), "stray entry fields")

  // clearing reports an empty table
  `DPR_ASSERT_IMP(a_clear_count, done && (status == ST_CLEARED),
    entry_count == '0, "count not zero after clear")

  // a result only shows while the block is idle again
  `DPR_ASSERT_IMP(a_done_idle, done, !busy, "result shown while busy")

endmodule

bind dedup_point_recorder dpr_checker u_dpr_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .status        (status),
  .entry_addr    (entry_addr),
  .entry_kind    (entry_kind),
  .entry_context (entry_context),
  .entry_count   (entry_count)
);
